### rtl/tops_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the tracked object publish throttle.
// Used by the cell, the ring and the top level; depends on nothing.
package tops_pkg;

	localparam int KEY_W = 56;
	localparam int TIME_W = 64;
	localparam int CFG_W = 48;
	localparam int SIG_W = 32;
	localparam int TOK_W = 4;
	localparam int BEAT_W = 32;
	localparam int DEC_W = 3;

	// at most this many exit beats per sweep; further stale entries wait
	localparam int MAX_EXITS = 32;

	localparam logic [TIME_W-1:0] PTS_NONE = '1;

	localparam logic [DEC_W-1:0] DEC_NONE   = 3'd0;
	localparam logic [DEC_W-1:0] DEC_FIRST  = 3'd1;
	localparam logic [DEC_W-1:0] DEC_BEAT   = 3'd2;
	localparam logic [DEC_W-1:0] DEC_BYPASS = 3'd3;
	localparam logic [DEC_W-1:0] DEC_EXIT   = 3'd4;
	localparam logic [DEC_W-1:0] DEC_DUP    = 3'd5;
	localparam logic [DEC_W-1:0] DEC_FULL   = 3'd6;
	localparam logic [DEC_W-1:0] DEC_DONE   = 3'd7;

	localparam logic [1:0] REG_CAPTURE = 2'd0;
	localparam logic [1:0] REG_REFILL  = 2'd1;
	localparam logic [1:0] REG_BURST   = 2'd2;
	localparam logic [1:0] REG_STALE   = 2'd3;

	typedef struct packed {
		logic              valid;
		logic [KEY_W-1:0]  key;
		logic [TIME_W-1:0] seen;
		logic [TIME_W-1:0] cap;
		logic [TIME_W-1:0] refr;
		logic [TOK_W-1:0]  tok;
		logic [BEAT_W-1:0] beat;
		logic [SIG_W-1:0]  lab;
		logic [SIG_W-1:0]  pay;
	} entry_t;

endpackage

### rtl/tops_cell.sv
`timescale 1ns / 1ps
// One table entry held in registers; loads its neighbor's entry on shift.
// Depends on tops_pkg.
module tops_cell
	import tops_pkg::*;
(
	input  logic   clk,
	input  logic   arst_n,
	input  logic   shift,
	input  logic   clr,
	input  entry_t d,
	output entry_t q
);

	logic   valid_q;
	entry_t data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (clr) begin
			valid_q <= 1'b0;
		end else if (shift) begin
			valid_q <= d.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (shift) begin
			data_q <= d;
		end
	end

	always_comb begin
		q = data_q;
		q.valid = valid_q;
	end

endmodule

### rtl/tops_ring.sv
`timescale 1ns / 1ps
// Ring of entry cells: every shift moves each entry one place toward the head,
// and the tail takes the written-back head entry. Depends on tops_pkg, tops_cell.
module tops_ring
	import tops_pkg::*;
#(
	parameter int DEPTH = 32
) (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   shift,
	input  logic   clr,
	input  entry_t wb,
	output entry_t head
);

	entry_t q [DEPTH];

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		entry_t d;
		if (i == DEPTH - 1) begin : g_tail
			assign d = wb;
		end else begin : g_mid
			assign d = q[i+1];
		end
		tops_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.shift  (shift),
			.clr    (clr),
			.d      (d),
			.q      (q[i])
		);
	end

	assign head = q[0];

endmodule

### rtl/tracked_object_publish_throttle.sv
`timescale 1ns / 1ps
// Observation hit: one ring turn, held at the matching entry for the match, calc, any refill
// division, decide and finish steps; a new object takes two turns, a full table one turn
// plus the result beat. Sweep: one ring turn plus the done beat, or only the done beat when
// sweeping is off; exits stall while the output waits.
// One item at a time, taken only while idle; the ring's single head position sets the rate.
// Reset clears all entry valid bits at once and loads the register defaults; no clearing pass.
module tracked_object_publish_throttle
	import tops_pkg::*;
#(
	parameter int TABLE_DEPTH = 32
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          s_tvalid,
	output logic          s_tready,
	input  logic [183:0]  s_tdata,  // source, tracker, pts, label sig, payload sig
	input  logic [0:0]    s_tuser,  // req_type
	output logic          m_tvalid,
	input  logic          m_tready,
	output logic [87:0]   m_tdata,  // out_source, out_tracker, beat_count
	output logic [2:0]    m_tuser,  // decision
	output logic          m_tlast,
	input  logic          psel,
	input  logic          penable,
	input  logic          pwrite,
	input  logic [4:0]    paddr,
	input  logic [63:0]   pwdata,
	output logic [63:0]   prdata,
	output logic          pready
);

	localparam int PW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int UW = $clog2(TABLE_DEPTH + 1);
	localparam int NW = $clog2(MAX_EXITS + 1);
	localparam logic [PW-1:0] POS_LAST = PW'(TABLE_DEPTH - 1);

	localparam logic [3:0] ST_IDLE   = 4'd0;
	localparam logic [3:0] ST_SCAN   = 4'd1;
	localparam logic [3:0] ST_CALC   = 4'd2;
	localparam logic [3:0] ST_DIV    = 4'd3;
	localparam logic [3:0] ST_DECIDE = 4'd4;
	localparam logic [3:0] ST_FIN    = 4'd5;
	localparam logic [3:0] ST_WRITE  = 4'd6;
	localparam logic [3:0] ST_ALLOC  = 4'd7;
	localparam logic [3:0] ST_FULL   = 4'd8;
	localparam logic [3:0] ST_SWEEP  = 4'd9;
	localparam logic [3:0] ST_DONE   = 4'd10;

	logic [3:0]        state_q;
	logic [PW-1:0]     pos_q;
	logic [PW-1:0]     free_idx_q;
	logic              free_found_q;
	logic              hit_q;
	logic [NW-1:0]     n_q;
	logic [UW-1:0]     used_q;

	logic [CFG_W-1:0]  ci_q;
	logic [CFG_W-1:0]  rp_q;
	logic [TOK_W-1:0]  bl_q;
	logic [CFG_W-1:0]  st_q;

	logic [KEY_W-1:0]  key_q;
	logic [TIME_W-1:0] pts_q;
	logic [TIME_W-1:0] now_q;
	logic [SIG_W-1:0]  lab_q;
	logic [SIG_W-1:0]  pay_q;
	entry_t            w_q;
	logic [DEC_W-1:0]  dec_q;
	logic [TIME_W-1:0] cap_el_q;
	logic [TIME_W-1:0] rem_q;
	logic [TOK_W-1:0]  qcnt_q;

	logic              m_tvalid_q;
	logic [DEC_W-1:0]  out_dec_q;
	logic [KEY_W-1:0]  out_key_q;
	logic [BEAT_W-1:0] out_beat_q;
	logic              out_last_q;

	entry_t            head;
	entry_t            wb;
	entry_t            new_ent;
	logic              shift;
	logic              clr;
	logic              emit;
	logic [DEC_W-1:0]  e_dec;
	logic [KEY_W-1:0]  e_key;
	logic [BEAT_W-1:0] e_beat;
	logic              e_last;
	logic              out_free;
	logic              accept;
	logic              match;
	logic              stale;
	logic              want_exit;
	logic [UW-1:0]     used_nxt;
	logic [TIME_W:0]   age_diff;
	logic [TIME_W:0]   ref_diff;
	logic [TIME_W:0]   cap_diff;
	logic [TOK_W:0]    tok_sum;
	logic [TOK_W-1:0]  tok_fill;
	logic              cfg_wr;

	// configuration port
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ci_q <= CFG_W'(1000000000);
			rp_q <= CFG_W'(1000000000);
			bl_q <= TOK_W'(3);
			st_q <= '0;
		end else if (cfg_wr) begin
			unique case (paddr[4:3])
				REG_CAPTURE: ci_q <= pwdata[CFG_W-1:0];
				REG_REFILL:  rp_q <= pwdata[CFG_W-1:0];
				REG_BURST:   bl_q <= pwdata[TOK_W-1:0];
				REG_STALE:   st_q <= pwdata[CFG_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[4:3])
			REG_CAPTURE: prdata = {16'd0, ci_q};
			REG_REFILL:  prdata = {16'd0, rp_q};
			REG_BURST:   prdata = {60'd0, bl_q};
			REG_STALE:   prdata = {16'd0, st_q};
			default:     prdata = '0;
		endcase
	end

	tops_ring #(.DEPTH(TABLE_DEPTH)) u_ring (
		.clk    (clk),
		.arst_n (arst_n),
		.shift  (shift),
		.clr    (clr),
		.wb     (wb),
		.head   (head)
	);

	assign s_tready = (state_q == ST_IDLE);
	assign accept   = s_tvalid && s_tready;
	assign out_free = !m_tvalid_q || m_tready;

	assign match    = head.valid && (head.key == key_q) && !hit_q;
	assign age_diff = {1'b0, now_q} - {1'b0, head.seen};
	assign stale    = (head.seen == PTS_NONE) ||
	                  (!age_diff[TIME_W] && (age_diff[TIME_W-1:0] > {16'd0, st_q}));
	assign want_exit = head.valid && stale && (n_q < NW'(MAX_EXITS));
	assign used_nxt = used_q + UW'(head.valid && !want_exit);

	assign ref_diff = {1'b0, pts_q} - {1'b0, w_q.refr};
	assign cap_diff = {1'b0, pts_q} - {1'b0, w_q.cap};
	assign tok_sum  = {1'b0, w_q.tok} + {1'b0, qcnt_q};
	assign tok_fill = (tok_sum > {1'b0, bl_q}) ? bl_q : tok_sum[TOK_W-1:0];

	always_comb begin
		new_ent       = '0;
		new_ent.valid = 1'b1;
		new_ent.key   = key_q;
		new_ent.seen  = pts_q;
		new_ent.cap   = pts_q;
		new_ent.refr  = pts_q;
		new_ent.tok   = bl_q;
		new_ent.lab   = lab_q;
		new_ent.pay   = pay_q;
	end

	// ring control and result beats
	always_comb begin
		shift  = 1'b0;
		clr    = 1'b0;
		wb     = head;
		emit   = 1'b0;
		e_dec  = DEC_NONE;
		e_key  = key_q;
		e_beat = '0;
		e_last = 1'b1;
		unique case (state_q)
			ST_SCAN: begin
				shift = !match;
			end
			ST_WRITE: begin
				if (out_free) begin
					shift  = 1'b1;
					wb     = w_q;
					emit   = 1'b1;
					e_dec  = dec_q;
					e_key  = w_q.key;
					e_beat = w_q.beat;
				end
			end
			ST_ALLOC: begin
				if (pos_q == free_idx_q) begin
					if (out_free) begin
						shift = 1'b1;
						wb    = new_ent;
						emit  = 1'b1;
						e_dec = DEC_FIRST;
					end
				end else begin
					shift = 1'b1;
				end
			end
			ST_FULL: begin
				emit  = out_free;
				e_dec = DEC_FULL;
			end
			ST_SWEEP: begin
				if (want_exit) begin
					if (out_free) begin
						shift    = 1'b1;
						wb.valid = 1'b0;
						emit     = 1'b1;
						e_dec    = DEC_EXIT;
						e_key    = head.key;
						e_last   = 1'b0;
					end
				end else begin
					shift = 1'b1;
				end
				clr = shift && (pos_q == POS_LAST) && (used_nxt == UW'(TABLE_DEPTH));
			end
			ST_DONE: begin
				emit  = out_free;
				e_dec = DEC_DONE;
				e_key = '0;
			end
			default: ;
		endcase
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			pos_q        <= '0;
			free_idx_q   <= '0;
			free_found_q <= 1'b0;
			hit_q        <= 1'b0;
			n_q          <= '0;
			used_q       <= '0;
			m_tvalid_q   <= 1'b0;
		end else begin
			if (emit) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			if (shift) begin
				pos_q <= (pos_q == POS_LAST) ? '0 : pos_q + PW'(1);
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						pos_q        <= '0;
						hit_q        <= 1'b0;
						free_found_q <= 1'b0;
						n_q          <= '0;
						used_q       <= '0;
						if (s_tuser[0]) begin
							state_q <= (st_q == '0) ? ST_DONE : ST_SWEEP;
						end else begin
							state_q <= ST_SCAN;
						end
					end
				end
				ST_SCAN: begin
					if (match) begin
						hit_q   <= 1'b1;
						state_q <= ST_CALC;
					end else begin
						if (!head.valid && !free_found_q) begin
							free_found_q <= 1'b1;
							free_idx_q   <= pos_q;
						end
						if (pos_q == POS_LAST) begin
							if (hit_q) begin
								state_q <= ST_IDLE;
							end else if (free_found_q || !head.valid) begin
								state_q <= ST_ALLOC;
							end else begin
								state_q <= ST_FULL;
							end
						end
					end
				end
				ST_CALC: begin
					if (ci_q == '0 || w_q.cap == PTS_NONE || pts_q == PTS_NONE) begin
						state_q <= ST_FIN;
					end else if (w_q.refr == PTS_NONE || ref_diff[TIME_W] ||
					             ref_diff == '0 || rp_q == '0) begin
						state_q <= ST_DECIDE;
					end else begin
						state_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					if (!(rem_q >= {16'd0, rp_q} && qcnt_q != '1)) begin
						state_q <= ST_DECIDE;
					end
				end
				ST_DECIDE: state_q <= ST_FIN;
				ST_FIN:    state_q <= ST_WRITE;
				ST_WRITE: begin
					if (shift) begin
						state_q <= (pos_q == POS_LAST) ? ST_IDLE : ST_SCAN;
					end
				end
				ST_ALLOC: begin
					if (shift && pos_q == POS_LAST) begin
						state_q <= ST_IDLE;
					end
				end
				ST_FULL: begin
					if (emit) begin
						state_q <= ST_IDLE;
					end
				end
				ST_SWEEP: begin
					if (shift) begin
						n_q    <= n_q + NW'(want_exit);
						used_q <= used_nxt;
						if (pos_q == POS_LAST) begin
							state_q <= ST_DONE;
						end
					end
				end
				ST_DONE: begin
					if (emit) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// working entry, refill arithmetic and output data
	always_ff @(posedge clk) begin
		if (accept) begin
			key_q <= {s_tdata[7:0], s_tdata[55:8]};
			pts_q <= s_tdata[119:56];
			lab_q <= s_tdata[151:120];
			pay_q <= s_tdata[183:152];
			now_q <= (s_tdata[119:56] == PTS_NONE) ? '0 : s_tdata[119:56];
		end
		if (emit) begin
			out_dec_q  <= e_dec;
			out_key_q  <= e_key;
			out_beat_q <= e_beat;
			out_last_q <= e_last;
		end
		case (state_q)
			ST_SCAN: begin
				if (match) begin
					w_q <= head;
				end
			end
			ST_CALC: begin
				cap_el_q <= cap_diff[TIME_W] ? '0 : cap_diff[TIME_W-1:0];
				rem_q    <= ref_diff[TIME_W-1:0];
				qcnt_q   <= '0;
				if (ci_q == '0 || w_q.cap == PTS_NONE || pts_q == PTS_NONE) begin
					dec_q <= DEC_BEAT;
				end else if (w_q.refr == PTS_NONE) begin
					w_q.refr <= pts_q;
					w_q.tok  <= bl_q;
				end else if (ref_diff[TIME_W] || ref_diff == '0) begin
					w_q.refr <= w_q.refr;
				end else if (rp_q == '0) begin
					w_q.refr <= pts_q;
					w_q.tok  <= bl_q;
				end
			end
			ST_DIV: begin
				// one subtraction a cycle; a quotient of 15 already fills any bucket
				if (rem_q >= {16'd0, rp_q} && qcnt_q != '1) begin
					rem_q  <= rem_q - {16'd0, rp_q};
					qcnt_q <= qcnt_q + TOK_W'(1);
				end else if (qcnt_q != '0) begin
					w_q.tok  <= tok_fill;
					w_q.refr <= pts_q;
				end
			end
			ST_DECIDE: begin
				if (cap_el_q >= {16'd0, ci_q}) begin
					dec_q <= DEC_BEAT;
				end else if (lab_q != '0 && lab_q != w_q.lab && w_q.tok != '0) begin
					w_q.tok <= w_q.tok - TOK_W'(1);
					dec_q   <= DEC_BYPASS;
				end else begin
					dec_q <= DEC_NONE;
				end
			end
			ST_FIN: begin
				w_q.seen <= pts_q;
				if (dec_q == DEC_BEAT && pay_q == w_q.pay) begin
					dec_q <= DEC_DUP;
				end else if (dec_q == DEC_BEAT || dec_q == DEC_BYPASS) begin
					if (dec_q == DEC_BEAT) begin
						w_q.beat <= w_q.beat + BEAT_W'(1);
					end
					w_q.cap <= pts_q;
					w_q.pay <= pay_q;
					w_q.lab <= lab_q;
				end
			end
			default: ;
		endcase
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tuser  = out_dec_q;
	assign m_tdata  = {out_beat_q, out_key_q[47:0], out_key_q[55:48]};
	assign m_tlast  = out_last_q;

endmodule

### test/tb_tracked_object_publish_throttle.sv
`timescale 1ns / 1ps
// Self-checking testbench for tracked_object_publish_throttle.
// Depends on tops_pkg and the DUT; a built-in throttle predictor checks every result beat.
module tb_tracked_object_publish_throttle;
	import tops_pkg::*;

	localparam int DEPTH = 32;
	localparam int WATCHDOG_LIMIT = 3000;
	localparam int SETTLE_CYCLES = 120;

	typedef struct {
		logic [DEC_W-1:0] decision;
		logic [7:0]       src;
		logic [47:0]      trk;
		logic [31:0]      beat;
		logic             last;
	} result_t;

	logic clk = 0;
	logic arst_n = 0;
	logic s_tvalid = 0;
	logic s_tready;
	logic [183:0] s_tdata = '0;  // source, tracker, pts, label sig, payload sig
	logic [0:0] s_tuser = '0;    // req_type
	logic m_tvalid;
	logic m_tready = 0;
	logic [87:0] m_tdata;        // out_source, out_tracker, beat_count
	logic [2:0] m_tuser;         // decision
	logic m_tlast;
	logic psel = 0, penable = 0, pwrite = 0;
	logic [4:0] paddr = '0;
	logic [63:0] pwdata = '0;
	logic [63:0] prdata;
	logic pready;

	tracked_object_publish_throttle dut (.*);

	always begin
		#5 clk = 1;
		#5 clk = 0;
	end

	// throttle state mirror
	bit [47:0] cfg_interval, cfg_refill, cfg_stale;
	bit [3:0]  cfg_burst;
	bit        obj_valid [DEPTH];
	bit [55:0] obj_key [DEPTH];
	bit [63:0] obj_seen [DEPTH], obj_capture [DEPTH], obj_refill [DEPTH];
	bit [3:0]  obj_tokens [DEPTH];
	bit [31:0] obj_beat [DEPTH], obj_lsig [DEPTH], obj_payload [DEPTH];

	result_t pending_results[$];
	int errors = 0, items_sent = 0, results_seen = 0, sweeps_sent = 0;
	int hold_cycles = 0;
	bit idling = 1;
	int idle_cycles = 0;

	function automatic void push_result(logic [2:0] d, bit [55:0] key, bit [31:0] b, bit l);
		result_t r;
		r.decision = d; r.src = key[55:48]; r.trk = key[47:0]; r.beat = b; r.last = l;
		pending_results.insert(pending_results.size(), r);
	endfunction

	function automatic void top_up_tokens(int i, bit [63:0] now);
		bit [63:0] el, q, t;
		if (now == PTS_NONE) return;
		if (obj_refill[i] == PTS_NONE) begin
			obj_refill[i] = now; obj_tokens[i] = cfg_burst; return;
		end
		if (now <= obj_refill[i]) return;
		el = now - obj_refill[i];
		if (cfg_refill == 0) begin
			obj_tokens[i] = cfg_burst; obj_refill[i] = now; return;
		end
		if (el >= cfg_refill) begin
			q = el / cfg_refill;
			if (q >= cfg_burst) t = cfg_burst;
			else begin
				t = obj_tokens[i] + q;
				if (t > cfg_burst) t = cfg_burst;
			end
			obj_tokens[i] = t[3:0];
			obj_refill[i] = now;
		end
	endfunction

	function automatic void predict_sweep(bit [63:0] now);
		int n, used;
		bit stale;
		n = 0; used = 0;
		if (now == PTS_NONE) now = 0;
		if (cfg_stale == 0) begin
			push_result(DEC_DONE, 0, 0, 1); return;
		end
		for (int i = 0; i < DEPTH; i++) begin
			if (!obj_valid[i]) continue;
			stale = (obj_seen[i] == PTS_NONE) ||
				(now > obj_seen[i] && now - obj_seen[i] > cfg_stale);
			if (stale && n < MAX_EXITS) begin
				push_result(DEC_EXIT, obj_key[i], 0, 0);
				n++;
				obj_valid[i] = 0;
			end
		end
		foreach (obj_valid[i]) if (obj_valid[i]) used++;
		if (used == DEPTH) foreach (obj_valid[i]) obj_valid[i] = 0;
		push_result(DEC_DONE, 0, 0, 1);
	endfunction

	function automatic void predict_observation(bit [7:0] src, bit [47:0] trk, bit [63:0] pts,
			bit [31:0] lab, bit [31:0] pay);
		bit [55:0] key;
		bit [63:0] el;
		logic [2:0] d;
		int hit, fr, i;
		key = {src, trk}; hit = -1; fr = -1;
		for (i = 0; i < DEPTH; i++) begin
			if (obj_valid[i] && obj_key[i] == key) begin
				if (hit < 0) hit = i;
			end else if (!obj_valid[i] && fr < 0) fr = i;
		end
		if (hit < 0) begin
			if (fr < 0) begin
				push_result(DEC_FULL, key, 0, 1); return;
			end
			obj_valid[fr] = 1; obj_key[fr] = key; obj_seen[fr] = pts;
			obj_capture[fr] = pts; obj_refill[fr] = pts; obj_tokens[fr] = cfg_burst;
			obj_beat[fr] = 0; obj_lsig[fr] = lab; obj_payload[fr] = pay;
			push_result(DEC_FIRST, key, 0, 1);
			return;
		end
		i = hit;
		obj_seen[i] = pts;
		if (cfg_interval == 0 || obj_capture[i] == PTS_NONE || pts == PTS_NONE) d = DEC_BEAT;
		else begin
			el = (pts >= obj_capture[i]) ? pts - obj_capture[i] : 0;
			top_up_tokens(i, pts);
			if (el >= cfg_interval) d = DEC_BEAT;
			else if (lab != 0 && lab != obj_lsig[i] && obj_tokens[i] > 0) begin
				obj_tokens[i] = obj_tokens[i] - 4'd1;
				d = DEC_BYPASS;
			end else d = DEC_NONE;
		end
		if (d == DEC_BEAT && pay == obj_payload[i]) d = DEC_DUP;
		if (d == DEC_BEAT || d == DEC_BYPASS) begin
			if (d == DEC_BEAT) obj_beat[i] = obj_beat[i] + 32'd1;
			obj_capture[i] = pts; obj_payload[i] = pay; obj_lsig[i] = lab;
		end
		push_result(d, key, obj_beat[i], 1);
	endfunction

	function automatic int pick_gap();
		int r;
		if (!idling) return 0;
		r = $urandom_range(0, 19);
		if (r < 10) return 0;
		if (r < 18) return $urandom_range(1, 3);
		return $urandom_range(15, 50);
	endfunction

	// called at a rising-edge step; returns at one
	task automatic send_beat(bit sweep, bit [7:0] src, bit [47:0] trk, bit [63:0] pts,
			bit [31:0] lab, bit [31:0] pay);
		int g;
		s_tvalid <= 1;
		s_tuser <= sweep;
		s_tdata <= {pay, lab, pts, trk, src};
		do @(posedge clk); while (!s_tready);
		if (sweep) begin
			predict_sweep(pts);
			sweeps_sent++;
		end else predict_observation(src, trk, pts, lab, pay);
		items_sent++;
		g = pick_gap();
		if (g > 0) begin
			s_tvalid <= 0;
			repeat (g) @(posedge clk);
		end
	endtask

	task automatic drain();
		s_tvalid <= 0;
		wait (pending_results.size() == 0);
		@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(logic [1:0] idx, bit [47:0] value);
		psel <= 1; pwrite <= 1; penable <= 0;
		paddr <= {idx, 3'b000};
		pwdata <= {16'h0, value};
		@(posedge clk);
		penable <= 1;
		@(posedge clk);
		psel <= 0; penable <= 0; pwrite <= 0;
		case (idx)
			REG_CAPTURE: cfg_interval = value;
			REG_REFILL:  cfg_refill = value;
			REG_BURST:   cfg_burst = value[3:0];
			REG_STALE:   cfg_stale = value;
		endcase
	endtask

	task automatic set_config(bit [47:0] iv, bit [47:0] rp, bit [3:0] bl, bit [47:0] st);
		write_reg(REG_CAPTURE, iv);
		write_reg(REG_REFILL, rp);
		write_reg(REG_BURST, bl);
		write_reg(REG_STALE, st);
	endtask

	// receiver: long hold on request, random stalls otherwise
	int rx_gap = 0;
	always @(posedge clk) begin
		if (hold_cycles > 0) begin
			m_tready <= 0;
			hold_cycles--;
		end else if (rx_gap > 0) begin
			m_tready <= 0;
			rx_gap--;
		end else begin
			m_tready <= 1;
			rx_gap = pick_gap();
		end
	end

	always @(posedge clk) begin
		result_t e;
		if (arst_n && m_tvalid && m_tready) begin
			results_seen++;
			if (pending_results.size() == 0) begin
				$error("result beat with nothing expected: decision %0d", m_tuser);
				errors++;
			end else begin
				e = pending_results.pop_front();
				if (m_tuser !== e.decision) begin
					$error("decision: expected %0d, got %0d", e.decision, m_tuser); errors++;
				end
				if (m_tdata[7:0] !== e.src) begin
					$error("out_source: expected %0h, got %0h", e.src, m_tdata[7:0]); errors++;
				end
				if (m_tdata[55:8] !== e.trk) begin
					$error("out_tracker: expected %0h, got %0h", e.trk, m_tdata[55:8]);
					errors++;
				end
				if (m_tdata[87:56] !== e.beat) begin
					$error("beat_count: expected %0d, got %0d", e.beat, m_tdata[87:56]);
					errors++;
				end
				if (m_tlast !== e.last) begin
					$error("last: expected %0b, got %0b", e.last, m_tlast); errors++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable))
			idle_cycles = 0;
		else idle_cycles++;
		if (idle_cycles > WATCHDOG_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	task automatic test_directed();
		bit [47:0] tmax;
		tmax = '1;
		// defaults: interval 1e9, refill 1e9, burst 3, sweeps disabled
		send_beat(0, 8'hFF, tmax, 0, 0, 32'hFFFF_FFFF);
		send_beat(0, 8'hFF, tmax, 10, 5, 1);            // label change spends a token
		send_beat(0, 8'hFF, tmax, 20, 5, 1);            // same label: nothing
		send_beat(0, 8'hFF, tmax, 30, 6, 1);
		send_beat(0, 8'hFF, tmax, 40, 7, 1);            // last token
		send_beat(0, 8'hFF, tmax, 50, 8, 1);            // bucket empty
		send_beat(0, 8'hFF, tmax, 64'd2_000_000_000, 8, 1);  // heartbeat with same payload
		send_beat(0, 8'hFF, tmax, 64'd3_000_000_000, 9, 2);
		send_beat(0, 8'hFF, tmax, PTS_NONE, 9, 3);      // invalid time
		send_beat(0, 8'hFF, tmax, 64'd4_000_000_000, 0, 4);  // stored capture invalid
		send_beat(0, 8'hFF, tmax, 1, 3, 4);             // time goes backwards
		send_beat(0, 8'hFF, tmax, 64'hFFFF_FFFF_FFFF_FFFE, 0, 32'hFFFF_FFFF);
		send_beat(0, 0, 0, PTS_NONE, 0, 0);
		send_beat(0, 0, 0, 5, 32'hFFFF_FFFF, 7);
		send_beat(0, 0, 0, 6, 1, 7);
		send_beat(1, 0, 0, 64'd9_000_000_000, 0, 0);    // sweeping off: done only
		drain();
	endtask

	task automatic test_full_table_and_sweeps();
		set_config(100, 0, 15, 5000);
		for (int k = 0; k < DEPTH; k++) send_beat(0, k[7:0], 48'h1000 + k, 100 + k, 0, k);
		send_beat(0, 8'h80, 48'hABC, 200, 0, 0);        // no free slot
		send_beat(0, 3, 48'h1003, 300, 2, 9);           // zero refill period
		send_beat(1, 0, 0, PTS_NONE, 0, 0);             // nothing stale, full table cleared
		send_beat(0, 1, 48'h2001, 1000, 0, 0);
		send_beat(0, 2, 48'h2002, PTS_NONE, 0, 0);
		send_beat(0, 3, 48'h2003, 9000, 0, 0);
		send_beat(1, 0, 0, 10000, 0, 0);
		send_beat(1, 0, 0, 10000, 0, 0);
		drain();
		// one exit for every slot
		for (int k = 0; k < DEPTH; k++) send_beat(0, 8'h40, k, k, 0, 0);
		send_beat(1, 0, 0, 64'd1_000_000, 0, 0);
		drain();
	endtask

	task automatic test_backpressure();
		set_config(0, 1, 1, 0);
		hold_cycles = 300;
		for (int k = 0; k < 8; k++) send_beat(0, 8'h11, 48'h77, k * 3, 0, k % 2);
		drain();                                        // sender waits for every result
		send_beat(1, 0, 0, 5, 0, 0);
		drain();
	endtask

	task automatic test_random();
		bit [7:0]  src_pool [6];
		bit [47:0] trk_pool [6];
		bit [31:0] lab_pool [3], pay_pool [3];
		bit [63:0] now, step;
		bit [47:0] iv;
		int p, r;
		for (int round = 0; round < 6; round++) begin
			case (round)
				0: set_config(1000, 400, 3, 5000);
				1: set_config(0, 1, 15, 48'hFFFF_FFFF_FFFF);
				2: set_config(48'hFFFF_FFFF_FFFF, 48'hFFFF_FFFF_FFFF, 1, 1);
				3: set_config(500, 0, 2, 3000);
				default: set_config($urandom_range(1, 4000), $urandom_range(0, 2000),
					4'($urandom_range(1, 15)), $urandom_range(0, 20000));
			endcase
			if (round == 4) write_reg(REG_BURST, 1);      // lower the limit mid-stream
			idling = (round != 2);
			iv = (cfg_interval == 0 || cfg_interval > 48'hFFFF_FFFF) ? 1000 : cfg_interval;
			foreach (src_pool[k]) begin
				src_pool[k] = 8'($urandom);
				trk_pool[k] = 48'({$urandom, $urandom});
			end
			src_pool[0] = 8'hFF; trk_pool[0] = '1;
			foreach (lab_pool[k]) begin
				lab_pool[k] = (k == 0) ? 0 : $urandom;
				pay_pool[k] = $urandom;
			end
			now = {$urandom_range(0, 255), 32'h0};
			for (int n = 0; n < 4; n++) begin
				r = $urandom_range(0, 19);
				case ($urandom_range(0, 5))
					0: step = 0;
					1: step = $urandom_range(1, 50);
					2: step = iv / 2;
					3: step = iv;
					4: step = 2 * iv + $urandom_range(0, 99);
					default: step = $urandom_range(0, 20000);
				endcase
				now = now + step;
				p = $urandom_range(0, 5);
				if (r == 0)
					send_beat(1, 0, 0, ($urandom_range(0, 3) == 0) ? PTS_NONE : now, 0, 0);
				else if (r == 1)
					send_beat($urandom_range(0, 3) == 0, 8'($urandom),
						48'({$urandom, $urandom}), {$urandom, $urandom}, $urandom, $urandom);
				else if (r == 2)
					send_beat(0, src_pool[p], trk_pool[p], PTS_NONE,
						lab_pool[$urandom_range(0, 2)], pay_pool[$urandom_range(0, 2)]);
				else if (r == 3)
					send_beat(0, src_pool[p], trk_pool[p], now - $urandom_range(1, 3000),
						lab_pool[$urandom_range(0, 2)], pay_pool[$urandom_range(0, 2)]);
				else
					send_beat(0, src_pool[p], trk_pool[p], now,
						lab_pool[$urandom_range(0, 2)], pay_pool[$urandom_range(0, 2)]);
			end
			send_beat(1, 0, 0, now + 64'd100_000, 0, 0);
			drain();
		end
	endtask

	initial begin
		cfg_interval = 1_000_000_000;
		cfg_refill = 1_000_000_000;
		cfg_burst = 3;
		cfg_stale = 0;
		foreach (obj_valid[i]) obj_valid[i] = 0;
		repeat (3) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		test_directed();
		test_full_table_and_sweeps();
		test_backpressure();
		test_random();
		$display("Covered %0d input beats (%0d sweeps) and %0d result beats", items_sent,
			sweeps_sent, results_seen);
		$display("over table fill and clear, token buckets, dedup and register extremes.");
		if (errors == 0 && pending_results.size() == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
